// File: sv/mvtm_pkg.sv
`default_nettype none
package mvtm_pkg;

  localparam int VOICE_COUNT    = 4;
  localparam int SINE_STEPS     = 256;
  localparam int DAC_FULL_SCALE = 4096;

  // Payload layout of the input and output transactions
  localparam int SEL_W      = 2;
  localparam int KIND_W     = 2;
  localparam int FIELD_W    = 16;
  localparam int IN_BITS    = SEL_W + KIND_W + 6 * FIELD_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int DAC_W      = 12;
  localparam int OUT_DATA_W = ((DAC_W + 7) / 8) * 8;

  localparam int OFS_SEL    = 0;
  localparam int OFS_KIND   = OFS_SEL + SEL_W;
  localparam int OFS_VOLUME = OFS_KIND + KIND_W;
  localparam int OFS_DECAY  = OFS_VOLUME + FIELD_W;
  localparam int OFS_LENGTH = OFS_DECAY + FIELD_W;
  localparam int OFS_PERIOD = OFS_LENGTH + FIELD_W;
  localparam int OFS_PHASE  = OFS_PERIOD + FIELD_W;
  localparam int OFS_STEP   = OFS_PHASE + FIELD_W;

  localparam int CNT_W      = 32;
  localparam int FRAC_W     = 8;

  localparam int VIDX_W     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int HALF_SCALE = DAC_FULL_SCALE / 2;
  localparam int SINE_W     = $clog2(DAC_FULL_SCALE) + 1;
  localparam int SINE_IDX_W = $clog2(SINE_STEPS);
  localparam bit SINE_POW2  = (SINE_STEPS == (1 << SINE_IDX_W));
  localparam int RED_W      = SINE_IDX_W + 2;
  localparam int SAMPLE_W   = (SINE_W > 14) ? SINE_W : 14;
  localparam int SUM_W      = SAMPLE_W + $clog2(VOICE_COUNT) + 2;
  localparam int TOT_W      = ((SUM_W > 17) ? SUM_W : 17) + 1;

  localparam int MUL_W      = 18;
  localparam int PROD_W     = 2 * MUL_W;

  localparam logic signed [TOT_W-1:0] MIX_HALF = TOT_W'(HALF_SCALE);
  localparam logic signed [TOT_W-1:0] MIX_MAX  = TOT_W'(DAC_FULL_SCALE - 1);

  typedef enum logic [KIND_W-1:0] {
    WAVE_SILENT = 2'd0,
    WAVE_NOISE  = 2'd1,
    WAVE_SQUARE = 2'd2,
    WAVE_SINE   = 2'd3
  } wave_kind_t;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // Sine table: trunc(HALF_SCALE * sin(2*pi*n/SINE_STEPS)), built at elaboration
  localparam logic [63:0] PI_HALF_Q31 = 64'd3373259426;
  localparam logic [63:0] ONE_Q31     = 64'd2147483648;
  localparam int          SERIES_LEN  = 14;

  localparam logic [9:0] SERIES_DIV_ODD [SERIES_LEN] = '{
    10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156, 10'd210,
    10'd272, 10'd342, 10'd420, 10'd506, 10'd600, 10'd702, 10'd812
  };
  localparam logic [9:0] SERIES_DIV_EVEN [SERIES_LEN] = '{
    10'd2, 10'd12, 10'd30, 10'd56, 10'd90, 10'd132, 10'd182,
    10'd240, 10'd306, 10'd380, 10'd462, 10'd552, 10'd650, 10'd756
  };

  typedef logic [SINE_STEPS-1:0][SINE_W-1:0] sine_rom_t;

  function automatic logic [63:0] series_q31(input logic [63:0] x, input bit odd);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    x2   = (x * x) >> 31;
    term = odd ? x : ONE_Q31;
    acc  = term;
    for (int i = 0; i < SERIES_LEN; i++) begin
      if (odd) begin
        term = ((term * x2) >> 31) / SERIES_DIV_ODD[i];
      end else begin
        term = ((term * x2) >> 31) / SERIES_DIV_EVEN[i];
      end
      if ((i % 2) == 0) begin
        acc = (acc >= term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] quarter_sine(input logic [63:0] k);
    logic [63:0] n;
    logic [63:0] v;
    n = 64'(SINE_STEPS);
    if (k == 64'd0) return 64'd0;
    if (k >= n) return 64'(HALF_SCALE);
    if (3 * k == n) return 64'(HALF_SCALE / 2);
    if (2 * k <= n) begin
      v = series_q31((k * PI_HALF_Q31 + n / 2) / SINE_STEPS, 1'b1);
    end else begin
      v = series_q31(((n - k) * PI_HALF_Q31 + n / 2) / SINE_STEPS, 1'b0);
    end
    if (v > ONE_Q31) v = ONE_Q31;
    return (64'(HALF_SCALE) * v) >> 31;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] v;
    for (int i = 0; i < SINE_STEPS; i++) begin
      m = 64'(4 * i);
      q = m / SINE_STEPS;
      r = m % SINE_STEPS;
      v = quarter_sine(q[0] ? 64'(SINE_STEPS) - r : r);
      rom[i] = (q >= 64'd2) ? SINE_W'(64'd0 - v) : SINE_W'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Residues of one byte of the integer phase, weighted by its position, modulo SINE_STEPS
  typedef logic [255:0][SINE_IDX_W-1:0] byte_mod_t;

  function automatic byte_mod_t build_byte_mod(input int shift);
    byte_mod_t   tbl;
    logic [63:0] x;
    for (int b = 0; b < 256; b++) begin
      x      = 64'(b) << shift;
      tbl[b] = SINE_IDX_W'(x % 64'(SINE_STEPS));
    end
    return tbl;
  endfunction

  localparam byte_mod_t IDX_MOD_LO  = build_byte_mod(0);
  localparam byte_mod_t IDX_MOD_MID = build_byte_mod(8);
  localparam byte_mod_t IDX_MOD_HI  = build_byte_mod(16);

endpackage
`default_nettype wire

// File: sv/mvtm_mul.sv
`default_nettype none
module mvtm_mul (
  input  logic                                 clk,
  input  logic signed [mvtm_pkg::MUL_W-1:0]    a,
  input  logic signed [mvtm_pkg::MUL_W-1:0]    b,
  output logic signed [mvtm_pkg::PROD_W-1:0]   p
);
  import mvtm_pkg::*;

  // Register the product; the sequencer reads it in the state after the one that drives the operands
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

// File: sv/multi_voice_tone_mixer.sv
`default_nettype none
// Load transaction: written in the cycle it is accepted; ready stays high.
// Tick transaction: a CHECK state per voice, then SCALE, DECAY, WRAP and WRITE per
//   active voice, with the one shared 18x18 multiplier serving three products per voice;
//   a sine voice adds an index reduction state when SINE_STEPS is not a power of two.
// The result sits in an output register; the next input is accepted meanwhile.
// Synchronous reset clears every voice to silent with zero duration.
module multi_voice_tone_mixer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // voice_select, wave_kind, start_volume, decay_rate, note_length,
  // period_samples, start_phase, phase_step, zero pad
  input  logic [mvtm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tuser,  // action
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mvtm_pkg::OUT_DATA_W-1:0]     m_axis_tdata   // dac_code, zero pad
);
  import mvtm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_REM   = 8'b0000_0100,
    S_SCALE = 8'b0000_1000,
    S_DECAY = 8'b0001_0000,
    S_WRAP  = 8'b0010_0000,
    S_WRITE = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;

  logic [FIELD_W-1:0] voice_volume   [VOICE_COUNT];
  logic [FIELD_W-1:0] voice_decay    [VOICE_COUNT];
  logic [FIELD_W-1:0] voice_duration [VOICE_COUNT];
  logic [FIELD_W-1:0] voice_period   [VOICE_COUNT];
  logic [CNT_W-1:0]   voice_counter  [VOICE_COUNT];
  logic [FIELD_W-1:0] voice_step     [VOICE_COUNT];
  wave_kind_t         voice_kind     [VOICE_COUNT];

  logic [VIDX_W-1:0]         vidx;
  logic signed [SAMPLE_W-1:0] raw_sample;
  logic signed [SUM_W-1:0]   mix;
  logic [RED_W-1:0]          rem;
  logic                      out_valid;
  logic [DAC_W-1:0]          out_code;

  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic [FIELD_W-1:0]        cur_vol;
  logic [FIELD_W-1:0]        cur_per;
  logic [CNT_W-1:0]          cur_cnt;
  logic [FIELD_W-1:0]        cur_step;
  wave_kind_t                cur_kind;
  logic [FIELD_W-1:0]        lfsr;
  logic [FIELD_W-1:0]        lfsr_next;
  logic [CNT_W-1:0]          sq_next;
  logic [CNT_W-1:0]          sine_next;
  logic [RED_W-1:0]          rem_sum;
  logic [RED_W-1:0]          rem_red;
  logic [SINE_IDX_W-1:0]     sine_idx;
  logic signed [SAMPLE_W-1:0] sine_val;
  logic signed [SAMPLE_W-1:0] scaled;
  logic signed [TOT_W-1:0]   total;
  logic [DAC_W-1:0]          dac_next;
  logic                      in_fire;
  logic                      out_load;
  logic                      last_voice;
  logic [VIDX_W-1:0]         load_idx;

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'(out_code);
  assign out_load      = (state == S_OUT) && (!out_valid || m_axis_tready);
  assign last_voice    = (vidx == VIDX_W'(VOICE_COUNT - 1));
  assign load_idx      = VIDX_W'(s_axis_tdata[OFS_SEL +: SEL_W]);

  always_comb begin
    cur_vol   = voice_volume[vidx];
    cur_per   = voice_period[vidx];
    cur_cnt   = voice_counter[vidx];
    cur_step  = voice_step[vidx];
    cur_kind  = voice_kind[vidx];

    lfsr      = cur_cnt[FIELD_W-1:0];
    lfsr_next = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[FIELD_W-1:1]};

    sq_next   = cur_cnt + CNT_W'(1);
    if (sq_next == CNT_W'(cur_per)) sq_next = '0;

    sine_next = cur_cnt + CNT_W'(cur_step);

    // Fold the three bytes of the integer phase by their residues, then trim below SINE_STEPS
    rem_sum   = RED_W'(IDX_MOD_LO[cur_cnt[FRAC_W +: 8]]) +
                RED_W'(IDX_MOD_MID[cur_cnt[FRAC_W + 8 +: 8]]) +
                RED_W'(IDX_MOD_HI[cur_cnt[FRAC_W + 16 +: 8]]);
    if (rem >= RED_W'(2 * SINE_STEPS)) begin
      rem_red = rem - RED_W'(2 * SINE_STEPS);
    end else if (rem >= RED_W'(SINE_STEPS)) begin
      rem_red = rem - RED_W'(SINE_STEPS);
    end else begin
      rem_red = rem;
    end
    if (SINE_POW2) begin
      sine_idx = cur_cnt[FRAC_W +: SINE_IDX_W];
    end else begin
      sine_idx = rem_red[SINE_IDX_W-1:0];
    end
    sine_val  = SAMPLE_W'($signed(SINE_ROM[sine_idx]));

    // Arithmetic shift floors toward minus infinity
    scaled    = prod[FIELD_W +: SAMPLE_W];

    total     = TOT_W'(mix) + MIX_HALF;
    if (total < 0) begin
      dac_next = '0;
    end else if (total > MIX_MAX) begin
      dac_next = MIX_MAX[DAC_W-1:0];
    end else begin
      dac_next = total[DAC_W-1:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SCALE: begin
        mul_a = MUL_W'(raw_sample);
        mul_b = MUL_W'(cur_vol);
      end
      S_DECAY: begin
        mul_a = MUL_W'(cur_vol);
        mul_b = MUL_W'((FIELD_W + 1)'(1 << FIELD_W) - (FIELD_W + 1)'(voice_decay[vidx]));
      end
      S_WRAP: begin
        mul_a = MUL_W'(cur_per);
        mul_b = MUL_W'(cur_step);
      end
      S_IDLE, S_CHECK, S_REM, S_WRITE, S_OUT: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mvtm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vidx      <= '0;
      out_valid <= 1'b0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        voice_volume[v]   <= '0;
        voice_decay[v]    <= '0;
        voice_duration[v] <= '0;
        voice_period[v]   <= '0;
        voice_counter[v]  <= '0;
        voice_step[v]     <= '0;
        voice_kind[v]     <= WAVE_SILENT;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser == ACT_LOAD) begin
              if (32'(s_axis_tdata[OFS_SEL +: SEL_W]) < VOICE_COUNT) begin
                voice_kind[load_idx]     <= wave_kind_t'(s_axis_tdata[OFS_KIND +: KIND_W]);
                voice_volume[load_idx]   <= s_axis_tdata[OFS_VOLUME +: FIELD_W];
                voice_decay[load_idx]    <= s_axis_tdata[OFS_DECAY +: FIELD_W];
                voice_duration[load_idx] <= s_axis_tdata[OFS_LENGTH +: FIELD_W];
                voice_period[load_idx]   <= s_axis_tdata[OFS_PERIOD +: FIELD_W];
                voice_counter[load_idx]  <= CNT_W'(s_axis_tdata[OFS_PHASE +: FIELD_W]);
                voice_step[load_idx]     <= s_axis_tdata[OFS_STEP +: FIELD_W];
              end
            end else begin
              vidx  <= '0;
              mix   <= '0;
              state <= S_CHECK;
            end
          end
        end

        S_CHECK: begin
          if (voice_duration[vidx] == '0) begin
            // skip idle voice
            if (last_voice) begin
              state <= S_OUT;
            end else begin
              vidx <= vidx + VIDX_W'(1);
            end
          end else begin
            unique case (cur_kind)
              WAVE_NOISE: begin
                voice_counter[vidx] <= CNT_W'(lfsr_next);
                raw_sample <= SAMPLE_W'(lfsr_next >> 4) - SAMPLE_W'(HALF_SCALE);
                state      <= S_SCALE;
              end
              WAVE_SQUARE: begin
                voice_counter[vidx] <= sq_next;
                raw_sample <= (cur_cnt < CNT_W'(cur_per >> 1)) ?
                              SAMPLE_W'(HALF_SCALE - 1) : -SAMPLE_W'(HALF_SCALE);
                state      <= S_SCALE;
              end
              WAVE_SINE: begin
                if (SINE_POW2) begin
                  raw_sample <= sine_val;
                  state      <= S_SCALE;
                end else begin
                  rem   <= rem_sum;
                  state <= S_REM;
                end
              end
              WAVE_SILENT: begin
                raw_sample <= '0;
                state      <= S_SCALE;
              end
              default: begin
                raw_sample <= '0;
                state      <= S_SCALE;
              end
            endcase
          end
        end

        S_REM: begin
          raw_sample <= sine_val;
          state      <= S_SCALE;
        end

        S_SCALE: begin
          state <= S_DECAY;
        end

        S_DECAY: begin
          mix   <= mix + SUM_W'(scaled);
          state <= S_WRAP;
        end

        S_WRAP: begin
          voice_volume[vidx] <= prod[FIELD_W +: FIELD_W];
          state              <= S_WRITE;
        end

        S_WRITE: begin
          if (cur_kind == WAVE_SINE) begin
            voice_counter[vidx] <= (sine_next > prod[CNT_W-1:0]) ? '0 : sine_next;
          end
          voice_duration[vidx] <= voice_duration[vidx] - FIELD_W'(1);
          if (last_voice) begin
            state <= S_OUT;
          end else begin
            vidx  <= vidx + VIDX_W'(1);
            state <= S_CHECK;
          end
        end

        S_OUT: begin
          // hold until the output register frees up
          if (out_load) begin
            out_code <= dac_next;
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: verif/tone_mix_checker.sv
module tone_mix_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [mvtm_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [mvtm_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                              mismatches,
  output int                              pending
);
  import mvtm_pkg::*;

  localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
  localparam logic [63:0] UNIT_Q31    = 64'd2147483648;

  int          sine_table [SINE_STEPS];
  wave_kind_t  tone_kind  [VOICE_COUNT];
  logic [15:0] tone_vol   [VOICE_COUNT];
  logic [15:0] tone_dec   [VOICE_COUNT];
  logic [15:0] tone_len   [VOICE_COUNT];
  logic [15:0] tone_per   [VOICE_COUNT];
  logic [15:0] tone_step  [VOICE_COUNT];
  logic [31:0] tone_ctr   [VOICE_COUNT];

  logic [DAC_W-1:0] dac_expect [$];
  int miss_count = 0;
  int backlog    = 0;

  assign mismatches = miss_count;
  assign pending    = backlog;

  // Alternating Taylor series in Q31: sine for odd, cosine otherwise.
  function automatic logic [63:0] taylor_q31(input logic [63:0] x, input bit odd);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] j;
    x2   = (x * x) >> 31;
    term = odd ? x : UNIT_Q31;
    acc  = term;
    j    = odd ? 64'd2 : 64'd1;
    for (int i = 0; i < 14; i++) begin
      term = ((term * x2) >> 31) / (j * (j + 64'd1));
      j    = j + 64'd2;
      if (i % 2 == 0) begin
        acc = (acc >= term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  // Amplitude at k steps of a quarter turn, 0 <= k <= SINE_STEPS.
  function automatic int quarter_wave(input logic [63:0] k);
    logic [63:0] n;
    logic [63:0] v;
    n = 64'(SINE_STEPS);
    if (k == 64'd0) return 0;
    if (k >= n) return HALF_SCALE;
    if (64'd3 * k == n) return HALF_SCALE / 2;
    if (64'd2 * k <= n) begin
      v = taylor_q31((k * HALF_PI_Q31 + n / 64'd2) / n, 1'b1);
    end else begin
      v = taylor_q31(((n - k) * HALF_PI_Q31 + n / 64'd2) / n, 1'b0);
    end
    if (v > UNIT_Q31) v = UNIT_Q31;
    return int'((64'(HALF_SCALE) * v) >> 31);
  endfunction

  initial begin
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] r;
    int          mag;
    for (int i = 0; i < SINE_STEPS; i++) begin
      m   = 64'(4 * i);
      q   = m / 64'(SINE_STEPS);
      r   = m % 64'(SINE_STEPS);
      mag = quarter_wave(q[0] ? 64'(SINE_STEPS) - r : r);
      sine_table[i] = (q >= 64'd2) ? -mag : mag;
    end
  end

  // Step every active voice once and return the saturated mix.
  function automatic logic [DAC_W-1:0] advance_voices();
    longint      mix;
    int          raw;
    logic [15:0] lf;
    logic [31:0] ctr;
    logic [31:0] per;
    logic [31:0] stp;
    mix = 0;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      if (tone_len[v] != 16'd0) begin
        ctr = tone_ctr[v];
        per = 32'(tone_per[v]);
        stp = 32'(tone_step[v]);
        case (tone_kind[v])
          WAVE_NOISE: begin
            lf  = ctr[15:0];
            lf  = {lf[0] ^ lf[2] ^ lf[3] ^ lf[5], lf[15:1]};
            ctr = 32'(lf);
            raw = int'(lf >> 4) - HALF_SCALE;
          end
          WAVE_SQUARE: begin
            raw = (ctr < per / 32'd2) ? HALF_SCALE - 1 : -HALF_SCALE;
            ctr = ctr + 32'd1;
            if (ctr == per) ctr = '0;
          end
          WAVE_SINE: begin
            raw = sine_table[(ctr >> 8) % 32'(SINE_STEPS)];
            ctr = ctr + stp;
            if (ctr > per * stp) ctr = '0;
          end
          default: begin
            raw = 0;
          end
        endcase
        tone_ctr[v] = ctr;
        // arithmetic shift rounds toward minus infinity
        mix = mix + ((longint'(raw) * longint'(tone_vol[v])) >>> 16);
        tone_vol[v] = 16'((32'(tone_vol[v]) * (32'd65536 - 32'(tone_dec[v]))) >> 16);
        tone_len[v] = tone_len[v] - 16'd1;
      end
    end
    mix = mix + HALF_SCALE;
    if (mix < 0) mix = 0;
    if (mix > DAC_FULL_SCALE - 1) mix = DAC_FULL_SCALE - 1;
    return DAC_W'(mix);
  endfunction

  always @(posedge clk) begin
    logic [DAC_W-1:0] want;
    logic [DAC_W-1:0] seen;
    int               sel;
    if (rst) begin
      for (int v = 0; v < VOICE_COUNT; v++) begin
        tone_kind[v] = WAVE_SILENT;
        tone_vol[v]  = '0;
        tone_dec[v]  = '0;
        tone_len[v]  = '0;
        tone_per[v]  = '0;
        tone_step[v] = '0;
        tone_ctr[v]  = '0;
      end
      dac_expect.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen = m_tdata[DAC_W-1:0];
        if (dac_expect.size() == 0) begin
          $error("dac_code: expected none, actual %0d", seen);
          miss_count++;
        end else begin
          want = dac_expect.pop_front();
          if (seen !== want) begin
            $error("dac_code: expected %0d, actual %0d", want, seen);
            miss_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == ACT_LOAD) begin
          sel = int'(s_tdata[OFS_SEL +: SEL_W]);
          // drop loads aimed past the last voice
          if (sel < VOICE_COUNT) begin
            tone_kind[sel] = wave_kind_t'(s_tdata[OFS_KIND +: KIND_W]);
            tone_vol[sel]  = s_tdata[OFS_VOLUME +: FIELD_W];
            tone_dec[sel]  = s_tdata[OFS_DECAY +: FIELD_W];
            tone_len[sel]  = s_tdata[OFS_LENGTH +: FIELD_W];
            tone_per[sel]  = s_tdata[OFS_PERIOD +: FIELD_W];
            tone_ctr[sel]  = 32'(s_tdata[OFS_PHASE +: FIELD_W]);
            tone_step[sel] = s_tdata[OFS_STEP +: FIELD_W];
          end
        end else begin
          dac_expect.push_back(advance_voices());
        end
      end
    end
    backlog <= dac_expect.size();
  end

endmodule

// File: verif/tb_multi_voice_tone_mixer.sv
module tb_multi_voice_tone_mixer;
  import mvtm_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = ACT_TICK;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int mismatches;
  int pending;
  bit steady        = 1'b0;
  bit stall_request = 1'b0;

  always #2 clk = ~clk;

  multi_voice_tone_mixer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tone_mix_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .s_tdata    (s_axis_tdata),
    .s_tuser    (s_axis_tuser),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  function automatic logic [IN_DATA_W-1:0] voice_word(input logic [1:0] sel,
                                                      input wave_kind_t kind,
                                                      input logic [15:0] vol, dec, len,
                                                      input logic [15:0] per, ph, stp);
    logic [IN_DATA_W-1:0] w;
    w = '0;
    w[OFS_SEL +: SEL_W]      = sel;
    w[OFS_KIND +: KIND_W]    = kind;
    w[OFS_VOLUME +: FIELD_W] = vol;
    w[OFS_DECAY +: FIELD_W]  = dec;
    w[OFS_LENGTH +: FIELD_W] = len;
    w[OFS_PERIOD +: FIELD_W] = per;
    w[OFS_PHASE +: FIELD_W]  = ph;
    w[OFS_STEP +: FIELD_W]   = stp;
    return w;
  endfunction

  function automatic logic [15:0] draw16(input int full_pct, input int small_max);
    if ($urandom_range(99) < full_pct) return 16'($urandom);
    return 16'($urandom_range(small_max, 0));
  endfunction

  // Offer one transaction, idling first at random unless steady, and hold it until accepted.
  task automatic send_item(input logic act, input logic [IN_DATA_W-1:0] word);
    if (!steady) begin
      while ($urandom_range(99) < 34) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= word;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic tick();
    logic [IN_DATA_W-1:0] w;
    w = IN_DATA_W'({$urandom, $urandom, $urandom, $urandom});
    w[IN_DATA_W-1:IN_BITS] = '0;
    send_item(ACT_TICK, w);
  endtask

  task automatic load_voice(input logic [1:0] sel, input wave_kind_t kind,
                            input logic [15:0] vol, dec, len, per, ph, stp);
    send_item(ACT_LOAD, voice_word(sel, kind, vol, dec, len, per, ph, stp));
  endtask

  task automatic random_item();
    if ($urandom_range(99) < 55) begin
      tick();
    end else begin
      load_voice(2'($urandom_range(3)), wave_kind_t'($urandom_range(3)),
                 draw16(70, 4096), draw16(20, 3000), draw16(8, 40),
                 draw16(20, 80), draw16(50, 600), draw16(25, 1024));
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: random backpressure unless steady, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_left    = 300;
        stall_request = 1'b0;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 34);
      end
    end
  end

  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all voices idle: half scale
    tick();
    // four loud squares saturate the top of the mix
    for (int v = 0; v < VOICE_COUNT; v++) begin
      load_voice(2'(v), WAVE_SQUARE, 16'hFFFF, 16'h0000, 16'd2, 16'd100, 16'd0, 16'd0);
    end
    tick();
    // zero period squares sit low and saturate the bottom
    for (int v = 0; v < VOICE_COUNT; v++) begin
      load_voice(2'(v), WAVE_SQUARE, 16'hFFFF, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
    end
    tick();
    // noise with zero seed, sine index past the table, silent decay, seeded noise
    load_voice(2'd0, WAVE_NOISE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
    load_voice(2'd1, WAVE_SINE, 16'h8000, 16'h0000, 16'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    load_voice(2'd2, WAVE_SILENT, 16'hFFFF, 16'h8000, 16'd5, 16'd7, 16'h1234, 16'd9);
    load_voice(2'd3, WAVE_NOISE, 16'h4000, 16'd100, 16'd4, 16'd0, 16'hACE1, 16'd0);
    repeat (3) tick();
    // inactive voice, then a sine that clears its counter
    load_voice(2'd0, WAVE_SINE, 16'hFFFF, 16'd0, 16'd0, 16'd50, 16'd0, 16'd256);
    load_voice(2'd1, WAVE_SINE, 16'hFFFF, 16'd0, 16'd20, 16'd3, 16'd0, 16'h0100);
    repeat (3) tick();
    load_voice(2'd3, WAVE_SQUARE, 16'hFFFF, 16'd0, 16'd10, 16'd1, 16'd0, 16'd0);
    tick();

    repeat (240) random_item();

    // hold off the output while ticks keep coming
    stall_request = 1'b1;
    repeat (30) tick();

    s_axis_tvalid <= 1'b0;
    wait_drained();

    steady = 1'b1;
    repeat (150) random_item();
    steady = 1'b0;

    repeat (210) random_item();

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (60) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
